// File: rtl/idct_pkg.sv
// Shared package for the 8x8 integer inverse DCT.
// Holds the transform constants, the controller state type and the
// command/status structs used between the controller and the datapath.
`default_nettype none

package idct_pkg;

	// Transform constants (W1..W7 scaled by 2048), rounding biases and pixel limits
	localparam logic signed [31:0] K_W1 = 32'sd2841;
	localparam logic signed [31:0] K_W2 = 32'sd2676;
	localparam logic signed [31:0] K_W3 = 32'sd2408;
	localparam logic signed [31:0] K_W5 = 32'sd1609;
	localparam logic signed [31:0] K_W6 = 32'sd1108;
	localparam logic signed [31:0] K_W7 = 32'sd565;
	localparam logic signed [39:0] K_R2 = 40'sd181;
	localparam logic signed [31:0] K_COL_BIAS = 32'sd8192;
	localparam logic signed [31:0] K_ROW_BIAS = 32'sd128;
	localparam logic signed [39:0] K_R2_BIAS = 40'sd128;
	localparam logic signed [31:0] K_COL_RB = 32'sd4;
	localparam logic signed [31:0] PIX_MIN = -32'sd256;
	localparam logic signed [31:0] PIX_MAX = 32'sd255;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DRAIN_R,
		ST_COLS,
		ST_DRAIN_C,
		ST_EMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic       issue;  // start one pass on the selected vector
		logic       col;    // column pass (else row pass)
		logic [2:0] idx;    // row number, column number or output row
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic busy;         // a pass is still in flight
	} sts_t;

endpackage

`default_nettype wire

// File: rtl/idct_8x8_integer_top.sv
// 8x8 integer inverse DCT, top level: row pass into a store, column pass
// into a sample buffer, then eight output rows. After the eighth input beat
// the controller drains the five-stage pass unit, issues the eight column
// passes, drains again and emits the rows; one block at a time, so no new
// block is taken until the last output row is accepted.
// Reset clears the controller and pass-unit valid flags; store and buffer do not.
`default_nettype none

module idct_8x8_integer_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] coef_0,
	input  wire logic signed [15:0] coef_1,
	input  wire logic signed [15:0] coef_2,
	input  wire logic signed [15:0] coef_3,
	input  wire logic signed [15:0] coef_4,
	input  wire logic signed [15:0] coef_5,
	input  wire logic signed [15:0] coef_6,
	input  wire logic signed [15:0] coef_7,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [8:0]       pix_0,
	output logic signed [8:0]       pix_1,
	output logic signed [8:0]       pix_2,
	output logic signed [8:0]       pix_3,
	output logic signed [8:0]       pix_4,
	output logic signed [8:0]       pix_5,
	output logic signed [8:0]       pix_6,
	output logic signed [8:0]       pix_7,
	output logic                    last_row
);

	idct_pkg::cmd_t cmd;
	idct_pkg::sts_t sts;

	idct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.last_row  (last_row),
		.cmd       (cmd),
		.sts       (sts)
	);

	idct_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.coef_0 (coef_0), .coef_1 (coef_1), .coef_2 (coef_2), .coef_3 (coef_3),
		.coef_4 (coef_4), .coef_5 (coef_5), .coef_6 (coef_6), .coef_7 (coef_7),
		.pix_0  (pix_0),  .pix_1  (pix_1),  .pix_2  (pix_2),  .pix_3  (pix_3),
		.pix_4  (pix_4),  .pix_5  (pix_5),  .pix_6  (pix_6),  .pix_7  (pix_7)
	);

endmodule

`default_nettype wire

// File: rtl/idct_ctrl.sv
// Controller for the 8x8 inverse DCT: sequences row load, column pass
// and row emission. Depends on idct_pkg for the state and command types.
`default_nettype none

module idct_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 last_row,
	output idct_pkg::cmd_t       cmd,
	input  wire idct_pkg::sts_t  sts
);

	idct_pkg::state_t state_q, state_d;
	logic [2:0] cnt_q;
	logic in_acc, out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			idct_pkg::ST_LOAD: begin
				if (in_acc && cnt_q == 3'd7) state_d = idct_pkg::ST_DRAIN_R;
			end
			idct_pkg::ST_DRAIN_R: begin
				if (!sts.busy) state_d = idct_pkg::ST_COLS;
			end
			idct_pkg::ST_COLS: begin
				if (cnt_q == 3'd7) state_d = idct_pkg::ST_DRAIN_C;
			end
			idct_pkg::ST_DRAIN_C: begin
				if (!sts.busy) state_d = idct_pkg::ST_EMIT;
			end
			idct_pkg::ST_EMIT: begin
				if (out_acc && cnt_q == 3'd7) state_d = idct_pkg::ST_LOAD;
			end
			default: state_d = idct_pkg::ST_LOAD;
		endcase
	end

	// Outputs and commands
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cmd.issue = 1'b0;
		cmd.col   = 1'b0;
		cmd.idx   = cnt_q;
		unique case (state_q)
			idct_pkg::ST_LOAD: begin
				in_stall  = 1'b0;
				cmd.issue = in_valid;
			end
			idct_pkg::ST_COLS: begin
				cmd.issue = 1'b1;
				cmd.col   = 1'b1;
			end
			idct_pkg::ST_EMIT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign last_row = (cnt_q == 3'd7);

	// State and beat counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idct_pkg::ST_LOAD;
			cnt_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			if ((state_q == idct_pkg::ST_LOAD && in_acc) ||
			    state_q == idct_pkg::ST_COLS ||
			    (state_q == idct_pkg::ST_EMIT && out_acc)) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/idct_dp.sv
// Datapath for the 8x8 inverse DCT: a five-stage 1-D pass unit shared by
// rows and columns, the row-pass store and the output sample buffer.
// Depends on idct_pkg for constants and the command/status structs.
`default_nettype none

module idct_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire idct_pkg::cmd_t       cmd,
	output idct_pkg::sts_t            sts,
	input  wire logic signed [15:0]   coef_0,
	input  wire logic signed [15:0]   coef_1,
	input  wire logic signed [15:0]   coef_2,
	input  wire logic signed [15:0]   coef_3,
	input  wire logic signed [15:0]   coef_4,
	input  wire logic signed [15:0]   coef_5,
	input  wire logic signed [15:0]   coef_6,
	input  wire logic signed [15:0]   coef_7,
	output logic signed [8:0]         pix_0,
	output logic signed [8:0]         pix_1,
	output logic signed [8:0]         pix_2,
	output logic signed [8:0]         pix_3,
	output logic signed [8:0]         pix_4,
	output logic signed [8:0]         pix_5,
	output logic signed [8:0]         pix_6,
	output logic signed [8:0]         pix_7
);

	// Row-pass store (one 8x16 row per entry) and output buffer
	logic [127:0] store_q [8];
	logic [71:0]  obuf_q  [8];

	// Tags along the pass unit
	logic       v_s0, v_s1, v_s2, v_s3, v_s4;
	logic       col_s0, col_s1, col_s2, col_s3, col_s4;
	logic [2:0] idx_s0, idx_s1, idx_s2, idx_s3, idx_s4;

	// Stage registers
	logic signed [15:0] b_s0 [8];
	logic signed [31:0] a8_s1, p4_s1, p5_s1, c8_s1, p6_s1, p7_s1;
	logic signed [31:0] d1_s1, p2_s1, p3_s1, e0_s1, e1_s1;
	logic signed [31:0] x8_s2, x0_s2, x2_s2, x3_s2, x1_s2, x4_s2, x6_s2, x5_s2;
	logic signed [31:0] x7_s3, x8_s3, x3_s3, x0_s3, x1_s3, x6_s3;
	logic signed [39:0] m2_s3, m4_s3;
	logic signed [15:0] res_s4 [8];

	logic signed [15:0] b_in [8];
	logic signed [31:0] rb;

	// Select operands: incoming coefficients or a column of the store
	always_comb begin
		if (cmd.col) begin
			for (int r = 0; r < 8; r++) begin
				b_in[r] = store_q[r][cmd.idx*16 +: 16];
			end
		end else begin
			b_in[0] = coef_0; b_in[1] = coef_1; b_in[2] = coef_2; b_in[3] = coef_3;
			b_in[4] = coef_4; b_in[5] = coef_5; b_in[6] = coef_6; b_in[7] = coef_7;
		end
	end

	assign rb = col_s0 ? idct_pkg::K_COL_RB : 32'sd0;

	// Tag pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0; v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_s0 <= cmd.issue; v_s1 <= v_s0; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		col_s0 <= cmd.col; col_s1 <= col_s0; col_s2 <= col_s1;
		col_s3 <= col_s2;  col_s4 <= col_s3;
		idx_s0 <= cmd.idx; idx_s1 <= idx_s0; idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;  idx_s4 <= idx_s3;
		if (cmd.issue) begin
			for (int k = 0; k < 8; k++) b_s0[k] <= b_in[k];
		end
	end

	// Stage 1: constant products
	always_ff @(posedge clk) begin
		a8_s1 <= idct_pkg::K_W7 * (32'(b_s0[1]) + 32'(b_s0[7])) + rb;
		p4_s1 <= (idct_pkg::K_W1 - idct_pkg::K_W7) * 32'(b_s0[1]);
		p5_s1 <= (idct_pkg::K_W1 + idct_pkg::K_W7) * 32'(b_s0[7]);
		c8_s1 <= idct_pkg::K_W3 * (32'(b_s0[5]) + 32'(b_s0[3])) + rb;
		p6_s1 <= (idct_pkg::K_W3 - idct_pkg::K_W5) * 32'(b_s0[5]);
		p7_s1 <= (idct_pkg::K_W3 + idct_pkg::K_W5) * 32'(b_s0[3]);
		d1_s1 <= idct_pkg::K_W6 * (32'(b_s0[2]) + 32'(b_s0[6])) + rb;
		p2_s1 <= (idct_pkg::K_W2 + idct_pkg::K_W6) * 32'(b_s0[6]);
		p3_s1 <= (idct_pkg::K_W2 - idct_pkg::K_W6) * 32'(b_s0[2]);
		if (col_s0) begin
			e0_s1 <= (32'(b_s0[0]) <<< 8) + idct_pkg::K_COL_BIAS;
			e1_s1 <= 32'(b_s0[4]) <<< 8;
		end else begin
			e0_s1 <= (32'(b_s0[0]) <<< 11) + idct_pkg::K_ROW_BIAS;
			e1_s1 <= 32'(b_s0[4]) <<< 11;
		end
	end

	// Stage 2: first butterflies, column prescale
	logic signed [31:0] t4, t5, t6, t7, t2, t3;
	always_comb begin
		t4 = a8_s1 + p4_s1;
		t5 = a8_s1 - p5_s1;
		t6 = c8_s1 - p6_s1;
		t7 = c8_s1 - p7_s1;
		t2 = d1_s1 - p2_s1;
		t3 = d1_s1 + p3_s1;
		if (col_s1) begin
			t4 = t4 >>> 3; t5 = t5 >>> 3; t6 = t6 >>> 3;
			t7 = t7 >>> 3; t2 = t2 >>> 3; t3 = t3 >>> 3;
		end
	end

	always_ff @(posedge clk) begin
		x8_s2 <= e0_s1 + e1_s1;
		x0_s2 <= e0_s1 - e1_s1;
		x2_s2 <= t2;
		x3_s2 <= t3;
		x1_s2 <= t4 + t6;
		x4_s2 <= t4 - t6;
		x6_s2 <= t5 + t7;
		x5_s2 <= t5 - t7;
	end

	// Stage 3: even butterflies and the sqrt(2) products
	always_ff @(posedge clk) begin
		x7_s3 <= x8_s2 + x3_s2;
		x8_s3 <= x8_s2 - x3_s2;
		x3_s3 <= x0_s2 + x2_s2;
		x0_s3 <= x0_s2 - x2_s2;
		x1_s3 <= x1_s2;
		x6_s3 <= x6_s2;
		m2_s3 <= idct_pkg::K_R2 * 40'(x4_s2 + x5_s2) + idct_pkg::K_R2_BIAS;
		m4_s3 <= idct_pkg::K_R2 * 40'(x4_s2 - x5_s2) + idct_pkg::K_R2_BIAS;
	end

	// Stage 4: output butterflies, final shift, truncate or clamp
	logic signed [31:0] y2, y4;
	logic signed [31:0] o [8];
	logic signed [31:0] sh [8];
	logic signed [15:0] res [8];
	always_comb begin
		y2 = 32'(m2_s3 >>> 8);
		y4 = 32'(m4_s3 >>> 8);
		o[0] = x7_s3 + x1_s3; o[1] = x3_s3 + y2; o[2] = x0_s3 + y4; o[3] = x8_s3 + x6_s3;
		o[4] = x8_s3 - x6_s3; o[5] = x0_s3 - y4; o[6] = x3_s3 - y2; o[7] = x7_s3 - x1_s3;
		for (int k = 0; k < 8; k++) begin
			if (col_s3) begin
				sh[k] = o[k] >>> 14;
				if (sh[k] < idct_pkg::PIX_MIN) sh[k] = idct_pkg::PIX_MIN;
				else if (sh[k] > idct_pkg::PIX_MAX) sh[k] = idct_pkg::PIX_MAX;
			end else begin
				sh[k] = o[k] >>> 8;
			end
			res[k] = sh[k][15:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 8; k++) res_s4[k] <= res[k];
	end

	// Write back: row results to the store, column results to the buffer
	always_ff @(posedge clk) begin
		if (v_s4 && !col_s4) begin
			store_q[idx_s4] <= {res_s4[7], res_s4[6], res_s4[5], res_s4[4],
			                    res_s4[3], res_s4[2], res_s4[1], res_s4[0]};
		end
		if (v_s4 && col_s4) begin
			for (int r = 0; r < 8; r++) begin
				obuf_q[r][idx_s4*9 +: 9] <= res_s4[r][8:0];
			end
		end
	end

	assign sts.busy = v_s0 | v_s1 | v_s2 | v_s3 | v_s4;

	// Present the selected output row
	assign pix_0 = obuf_q[cmd.idx][8:0];
	assign pix_1 = obuf_q[cmd.idx][17:9];
	assign pix_2 = obuf_q[cmd.idx][26:18];
	assign pix_3 = obuf_q[cmd.idx][35:27];
	assign pix_4 = obuf_q[cmd.idx][44:36];
	assign pix_5 = obuf_q[cmd.idx][53:45];
	assign pix_6 = obuf_q[cmd.idx][62:54];
	assign pix_7 = obuf_q[cmd.idx][71:63];

endmodule

`default_nettype wire

// File: verif/idct_8x8_integer_top_tb.sv
// Self-checking testbench for the 8x8 integer inverse DCT top level.
// Drives coefficient rows, predicts sample rows with its own transform
// model and checks every output beat; depends on rtl/idct_8x8_integer_top.sv.
`default_nettype none

module idct_8x8_integer_top_tb;

	typedef logic signed [15:0] coef_row_t [8];
	typedef struct {
		logic signed [8:0] pix [8];
		logic              last;
	} pix_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] coef [8];
	logic out_valid;
	logic out_stall = 1'b1;
	logic signed [8:0] pix [8];
	logic last_row;

	pix_row_t expected_rows [$];
	logic signed [15:0] row_store [64];
	int unsigned rows_seen = 0;
	int unsigned mismatches = 0;
	bit stim_done = 1'b0;
	bit quiet_phase = 1'b0;
	bit hold_off = 1'b0;

	initial begin
		for (int k = 0; k < 8; k++) begin
			coef[k] = '0;
		end
	end

	idct_8x8_integer_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.coef_0(coef[0]), .coef_1(coef[1]), .coef_2(coef[2]), .coef_3(coef[3]),
		.coef_4(coef[4]), .coef_5(coef[5]), .coef_6(coef[6]), .coef_7(coef[7]),
		.out_valid(out_valid), .out_stall(out_stall),
		.pix_0(pix[0]), .pix_1(pix[1]), .pix_2(pix[2]), .pix_3(pix[3]),
		.pix_4(pix[4]), .pix_5(pix[5]), .pix_6(pix[6]), .pix_7(pix[7]),
		.last_row(last_row)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic longint floor_shift(longint v, int k);
		return v >>> k;
	endfunction

	// One 1-D Chen-Wang butterfly pass; col selects column scaling and rounding
	function automatic void butterfly(input longint b [8], input bit col, output longint o [8]);
		longint x0, x1, x2, x3, x4, x5, x6, x7, x8, rb;
		rb = col ? 4 : 0;
		x1 = b[4] * (col ? 256 : 2048);
		x2 = b[6]; x3 = b[2]; x4 = b[1];
		x5 = b[7]; x6 = b[5]; x7 = b[3];
		x0 = col ? b[0] * 256 + 8192 : b[0] * 2048 + 128;
		x8 = 565 * (x4 + x5) + rb;
		x4 = x8 + (2841 - 565) * x4;
		x5 = x8 - (2841 + 565) * x5;
		x8 = 2408 * (x6 + x7) + rb;
		x6 = x8 - (2408 - 1609) * x6;
		x7 = x8 - (2408 + 1609) * x7;
		if (col) begin
			x4 = floor_shift(x4, 3); x5 = floor_shift(x5, 3);
			x6 = floor_shift(x6, 3); x7 = floor_shift(x7, 3);
		end
		x8 = x0 + x1;
		x0 -= x1;
		x1 = 1108 * (x3 + x2) + rb;
		x2 = x1 - (2676 + 1108) * x2;
		x3 = x1 + (2676 - 1108) * x3;
		if (col) begin
			x2 = floor_shift(x2, 3); x3 = floor_shift(x3, 3);
		end
		x1 = x4 + x6;
		x4 -= x6;
		x6 = x5 + x7;
		x5 -= x7;
		x7 = x8 + x3;
		x8 -= x3;
		x3 = x0 + x2;
		x0 -= x2;
		x2 = floor_shift(181 * (x4 + x5) + 128, 8);
		x4 = floor_shift(181 * (x4 - x5) + 128, 8);
		o[0] = x7 + x1; o[1] = x3 + x2; o[2] = x0 + x4; o[3] = x8 + x6;
		o[4] = x8 - x6; o[5] = x0 - x4; o[6] = x3 - x2; o[7] = x7 - x1;
	endfunction

	// Row-pass one beat into the store; after the eighth, queue eight sample rows
	task automatic predict_block(input coef_row_t c);
		longint b [8];
		longint o [8];
		longint v;
		pix_row_t rows [8];
		int r;
		r = rows_seen;
		for (int k = 0; k < 8; k++) b[k] = c[k];
		butterfly(b, 1'b0, o);
		for (int k = 0; k < 8; k++) row_store[r * 8 + k] = 16'(floor_shift(o[k], 8));
		rows_seen = (r + 1) % 8;
		if (r != 7) return;
		for (int col = 0; col < 8; col++) begin
			for (int k = 0; k < 8; k++) b[k] = row_store[k * 8 + col];
			butterfly(b, 1'b1, o);
			for (int k = 0; k < 8; k++) begin
				v = floor_shift(o[k], 14);
				if (v < -256) v = -256;
				if (v > 255) v = 255;
				rows[k].pix[col] = 9'(v);
			end
		end
		for (int k = 0; k < 8; k++) begin
			rows[k].last = (k == 7);
			expected_rows.push_back(rows[k]);
		end
	endtask

	// Offer one beat, hold it until accepted, then predict it
	task automatic send_row(input coef_row_t c);
		while (!quiet_phase && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		for (int k = 0; k < 8; k++) coef[k] <= c[k];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_block(c);
	endtask

	function automatic logic signed [15:0] rand_coef(input int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 64)) - 16'sd32;
			2: return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
			default: return 16'($urandom_range(0, 2048)) - 16'sd1024;
		endcase
	endfunction

	// Stimulus: directed blocks from a table, then random blocks
	initial begin
		coef_row_t directed [24];
		coef_row_t c;
		int mode;
		for (int r = 0; r < 24; r++) begin
			for (int k = 0; k < 8; k++) begin
				case (r / 8)
					0: directed[r][k] = '0;
					1: directed[r][k] = 16'sh7fff;
					default: directed[r][k] = ((r + k) % 2) ? 16'sh8000 : 16'sh7fff;
				endcase
			end
		end
		// DC-only block: flat output of (dc + 4) >> 3 style rounding
		directed[0][0] = 16'sd80;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < 24; r++) send_row(directed[r]);
		for (int blk = 0; blk < 47; blk++) begin
			quiet_phase = (blk >= 20 && blk < 26);
			hold_off = (blk == 30);
			for (int r = 0; r < 8; r++) begin
				mode = $urandom_range(0, 7);
				for (int k = 0; k < 8; k++) begin
					c[k] = (mode < 3 && k > 0 && r > 0 && $urandom_range(1)) ? 16'sd0
						: rand_coef(mode % 4);
				end
				send_row(c);
			end
		end
		quiet_phase = 1'b0;
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: random stall, plus one long hold-off while rows keep coming
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (120) @(posedge clk);
				hold_off = 1'b0;
			end
			out_stall <= (!quiet_phase && $urandom_range(99) < 27);
			@(posedge clk);
		end
	end

	// Check each accepted sample row against the oldest prediction
	always @(posedge clk) begin
		pix_row_t exp_row;
		bit bad;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected output beat");
			end else begin
				exp_row = expected_rows.pop_front();
				bad = (last_row !== exp_row.last);
				for (int k = 0; k < 8; k++) if (pix[k] !== exp_row.pix[k]) bad = 1'b1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp %p last %0d", exp_row.pix, exp_row.last);
						$display("          got %p last %0d", pix, last_row);
					end
				end
			end
		end
	end

	// Drain, settle, and report
	initial begin
		wait (stim_done);
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_rows.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
